// ===== rtl/core/bls_pkg.sv =====
// Package for the bounded list store: payload structs, opcode and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package bls_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_MODIFY = 2'd1,
    OP_APPEND = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  position;
    logic [30:0] datum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_at;
    logic [30:0] previous_value;
    logic [8:0]  live_count;
  } res_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_MOD_RD,
    S_MOD_WR,
    S_SHIFT,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    scan_find_init;
    logic    scan_shift_init;
    logic    scan_run;
    logic    shift_wr;
    logic    rd_pos;
    logic    mem_modify;
    logic    mem_append;
    logic    capture_prev;
    logic    set_found;
    logic    set_status;
    status_t status_code;
    logic    cnt_dec;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  opcode;
    logic in_range;
    logic full;
    logic scan_more;
    logic chk_valid;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/bls_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bls_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bls_dp.sv =====
// Datapath of the bounded list store: item register, live count, scan pointer,
// entry RAM and result/output registers. Depends on bls_pkg and bls_ram.
module bls_dp
  import bls_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output res_item_t out_data,
  input  cmd_t      cmd,
  output stat_t     stat
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 8) ? CW : 8;
  localparam int unsigned LW = (CW > 9) ? CW : 9;

  in_item_t        item;
  logic [CW-1:0]   count;
  logic [CW-1:0]   scan_idx;
  logic            chk_valid;
  logic [AW-1:0]   chk_idx;
  logic [1:0]      res_status;
  logic [7:0]      res_found;
  logic [30:0]     res_prev;

  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   cnt_pw;
  logic [PW-1:0]   found_ext;
  logic [LW-1:0]   cnt_lw;
  logic [AW-1:0]   pos_addr;
  logic            scan_more;
  logic            issue;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [30:0]     wr_data;
  logic [AW-1:0]   rd_addr;
  logic [30:0]     rd_data;

  // Widened views for compares and output fields
  assign pos_ext   = PW'(item.position);
  assign cnt_pw    = PW'(count);
  assign found_ext = PW'(chk_idx);
  assign cnt_lw    = LW'(count);
  assign pos_addr  = AW'(pos_ext);
  assign scan_more = (scan_idx < count);
  assign issue     = cmd.scan_run && scan_more;

  // Status back to the controller
  assign stat.opcode    = op_t'(item.opcode);
  assign stat.in_range  = (pos_ext < cnt_pw);
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.scan_more = scan_more;
  assign stat.chk_valid = chk_valid;
  assign stat.hit       = chk_valid && (rd_data == item.datum);
  assign stat.out_free  = !out_valid || !out_stall;

  // RAM port muxing
  assign rd_addr = cmd.rd_pos ? pos_addr : AW'(scan_idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_addr;
    wr_data = item.datum;
    if (cmd.mem_modify) begin
      wr_en = 1'b1;
    end else if (cmd.mem_append) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
    end else if (cmd.shift_wr && chk_valid) begin
      // entry read at chk_idx moves down one slot
      wr_en   = 1'b1;
      wr_addr = chk_idx - AW'(1);
      wr_data = rd_data;
    end
  end

  bls_ram #(
    .WIDTH (31),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Live count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.mem_append) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // Scan pointer and read-tracking stage
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_find_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_shift_init) begin
      scan_idx <= CW'(pos_ext) + CW'(1);
    end else if (issue) begin
      scan_idx <= scan_idx + CW'(1);
    end
    if (issue) begin
      chk_idx <= AW'(scan_idx);
    end
  end

  // Item and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item       <= in_data;
      res_status <= ST_OK;
      res_found  <= '0;
      res_prev   <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.set_found) begin
        res_found <= found_ext[7:0];
      end
      if (cmd.capture_prev) begin
        res_prev <= rd_data;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status         <= res_status;
      out_data.found_at       <= res_found;
      out_data.previous_value <= res_prev;
      out_data.live_count     <= cnt_lw[8:0];
    end
  end

endmodule

// ===== rtl/core/bls_ctrl.sv =====
// Controller of the bounded list store: sequences each operation and drives
// the datapath by command struct. Depends on bls_pkg.
module bls_ctrl
  import bls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  logic scan_done;
  assign scan_done = !stat.chk_valid && !stat.scan_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_FIND:   state_next = S_FIND;
          OP_MODIFY: state_next = stat.in_range ? S_MOD_RD : S_FINISH;
          OP_APPEND: state_next = S_FINISH;
          OP_REMOVE: state_next = stat.in_range ? S_SHIFT : S_FINISH;
          default:   state_next = S_FINISH;
        endcase
      end
      S_FIND: begin
        if (stat.hit || scan_done) state_next = S_FINISH;
      end
      S_MOD_RD: state_next = S_MOD_WR;
      S_MOD_WR: state_next = S_FINISH;
      S_SHIFT: begin
        if (scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd             = '0;
    cmd.status_code = ST_OK;
    in_stall        = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_FIND: begin
            cmd.scan_find_init = 1'b1;
            cmd.set_status     = 1'b1;
            cmd.status_code    = ST_NOT_FOUND;
          end
          OP_MODIFY: begin
            if (!stat.in_range) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.mem_append = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (stat.in_range) begin
              cmd.scan_shift_init = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_FIND: begin
        cmd.scan_run = 1'b1;
        if (stat.hit) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          cmd.set_found   = 1'b1;
        end
      end
      S_MOD_RD: begin
        cmd.rd_pos = 1'b1;
      end
      S_MOD_WR: begin
        cmd.mem_modify   = 1'b1;
        cmd.capture_prev = 1'b1;
      end
      S_SHIFT: begin
        cmd.scan_run = 1'b1;
        cmd.shift_wr = 1'b1;
        cmd.cnt_dec  = scan_done;
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/bounded_list_store_top.sv =====
// Bounded list store: a list of 31-bit values with find, modify, append and
// remove-with-compaction, one result beat per input beat, one item in flight.
// Append and any rejected operation go from dispatch straight to the finish
// state; modify reads the entry at the position and then writes it, keeping the
// old value. Find reads one entry a cycle from the entry RAM until a match or
// the end of the list. Remove moves each entry after the position down one slot,
// one entry a cycle (read and write on the RAM's two ports). The next beat is
// taken in the cycle after the result is loaded; with the single RAM read port,
// the worst case is a find with no match on a full list. The result sits in an
// output register, so a new beat is taken as soon as the result is loaded even
// if the consumer stalls. A result that finds the output register still held
// waits in its last cycle.
// No clearing pass after reset.
// Depends on bls_pkg, bls_ctrl, bls_dp, bls_ram.
module bounded_list_store_top
  import bls_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output res_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  bls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bls_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
